FILE: design/led_strip_pattern_sequencer_macros.svh
// Assertion macros used by the checker of the LED pattern sequencer.
`ifndef LED_STRIP_PATTERN_SEQUENCER_MACROS_SVH
`define LED_STRIP_PATTERN_SEQUENCER_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define LSPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LSPS_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/lsps_pkg.sv
// Package with the sizes, phase bounds and LED bit helper of the pattern sequencer.
`timescale 1ns / 1ps

package lsps_pkg;

    localparam int LED_COUNT = 8;
    localparam int PAT_W     = 8;
    localparam int PAT_IDX_W = 3;
    localparam int STEP_W    = 8;
    localparam int TIME_W    = 32;
    localparam int IVAL_W    = 16;
    localparam int OUT_DW    = 16;

    localparam logic [TIME_W-1:0] IVAL_RESET = TIME_W'(100);

    // Phase bounds on the incremented step.
    localparam logic [STEP_W-1:0] STEP_ONE   = STEP_W'(1);
    localparam logic [STEP_W-1:0] LED_N      = STEP_W'(LED_COUNT);
    localparam logic [STEP_W-1:0] LED_TOP    = STEP_W'(LED_COUNT - 1);
    localparam logic [STEP_W-1:0] LED_HALF   = STEP_W'(LED_COUNT / 2);
    localparam logic [STEP_W-1:0] LED_LOWMID = STEP_W'((LED_COUNT - 1) / 2);
    localparam logic [STEP_W-1:0] CLR_OFS    = STEP_W'(LED_COUNT + 1);
    localparam logic [STEP_W-1:0] RUN_LO     = STEP_W'(2 * LED_COUNT);
    localparam logic [STEP_W-1:0] RUN_REF    = STEP_W'(3 * LED_COUNT - 2);
    localparam logic [STEP_W-1:0] MIR_LO     = STEP_W'(3 * LED_COUNT - 1);
    localparam logic [STEP_W-1:0] TWO_LO     = STEP_W'(4 * LED_COUNT - 3);
    localparam logic [STEP_W-1:0] TWO_OFS    = STEP_W'(4 * LED_COUNT - 5);
    localparam logic [STEP_W-1:0] SEQ_END    = STEP_W'(5 * LED_COUNT - 4);

    typedef struct packed {
        logic             restart;
        logic [PAT_W-1:0] pattern;
    } t_phase_res;

    // One-hot mask for an LED index; indexes past the pattern give no bit.
    function automatic logic [PAT_W-1:0] f_led_bit(input logic [STEP_W-1:0] idx);
        logic [PAT_W-1:0] mask;
        mask = '0;
        if (idx < STEP_W'(PAT_W)) begin
            mask = PAT_W'(1) << idx[PAT_IDX_W-1:0];
        end
        return mask;
    endfunction

endpackage

FILE: design/lsps_phase.sv
// Phase decoder: maps the incremented step and the current pattern to the next pattern.
`timescale 1ns / 1ps

module lsps_phase (
    input  logic [lsps_pkg::STEP_W-1:0] i_step,
    input  logic [lsps_pkg::PAT_W-1:0]  i_pattern,
    output lsps_pkg::t_phase_res        o_res
);
    import lsps_pkg::*;

    logic [STEP_W-1:0] k_idx;
    logic [STEP_W-1:0] j_idx;
    logic [STEP_W-1:0] m_idx;
    logic [STEP_W-1:0] run_idx;
    logic [STEP_W-1:0] two_idx;

    assign run_idx = RUN_REF - i_step;
    assign k_idx   = i_step - RUN_REF;
    assign j_idx   = k_idx - LED_HALF;
    assign m_idx   = i_step - TWO_OFS;
    assign two_idx = LED_N - m_idx;

    always_comb begin
        o_res.restart = 1'b0;
        o_res.pattern = i_pattern;
        if (i_step >= STEP_ONE && i_step <= LED_N) begin
            o_res.pattern = i_pattern | f_led_bit(i_step - STEP_ONE);
        end else if (i_step > LED_N && i_step < RUN_LO) begin
            o_res.pattern = i_pattern & ~f_led_bit(i_step - CLR_OFS);
        end else if (i_step >= RUN_LO && i_step < MIR_LO) begin
            o_res.pattern = f_led_bit(LED_TOP) | f_led_bit(run_idx);
        end else if (i_step >= MIR_LO && i_step < TWO_LO) begin
            // Fill inward from both ends, then clear outward from the middle.
            if (k_idx < LED_HALF) begin
                o_res.pattern = i_pattern | f_led_bit(LED_TOP - k_idx) | f_led_bit(k_idx);
            end else begin
                o_res.pattern = i_pattern & ~(f_led_bit(LED_LOWMID - j_idx)
                                              | f_led_bit(LED_HALF + j_idx));
            end
        end else if (i_step >= TWO_LO && i_step < SEQ_END) begin
            o_res.pattern = f_led_bit(two_idx);
            if (two_idx >= LED_HALF) begin
                o_res.pattern = f_led_bit(two_idx) | f_led_bit(m_idx);
            end
        end else begin
            o_res.restart = 1'b1;
        end
    end

endmodule

FILE: design/led_strip_pattern_sequencer.sv
// Top level of the LED pattern sequencer: input register, step state and result register.
//
//  channel   direction  signals                       payload
//  s_axis    in         tvalid / tready / tdata[31:0] time_now
//  m_axis    out        tvalid / tready / tdata[15:0] led_pattern, stepped
//  cfg       in         valid / ready / data[15:0]    step_interval
//
// An accepted item waits in the input register; an edge on which the output can advance
// moves it through the deadline compare and phase decode into the result register, where
// it is offered. One item is accepted every cycle unless the result stalls.
// Reset clears step count, deadline and pattern and loads an interval of 100.
// A stall holds the output and a full input register; input ready drops only then.
`timescale 1ns / 1ps

module led_strip_pattern_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [lsps_pkg::TIME_W-1:0]   i_s_axis_tdata,   // [31:0] time_now
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [lsps_pkg::OUT_DW-1:0]   o_m_axis_tdata,   // [7:0] led_pattern, [8] stepped
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lsps_pkg::IVAL_W-1:0]   i_cfg_data        // [15:0] step_interval
);
    import lsps_pkg::*;

    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_time;
    logic              r_out_valid;
    logic [PAT_W-1:0]  r_out_pattern;
    logic              r_out_stepped;
    logic [STEP_W-1:0] r_step;
    logic [TIME_W-1:0] r_deadline;
    logic [PAT_W-1:0]  r_pattern;
    logic [IVAL_W-1:0] r_interval;

    logic [STEP_W-1:0] n_step;
    logic [TIME_W-1:0] n_deadline;
    logic [PAT_W-1:0]  n_pattern;
    logic              advance;
    logic              stepped;
    logic [STEP_W-1:0] step_inc;
    t_phase_res        phase_res;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DW - PAT_W - 1)'(0), r_out_stepped, r_out_pattern};

    assign stepped  = r_deadline < r_in_time;
    assign step_inc = r_step + STEP_ONE;

    lsps_phase u_phase (
        .i_step    (step_inc),
        .i_pattern (r_pattern),
        .o_res     (phase_res)
    );

    always_comb begin
        n_step     = r_step;
        n_deadline = r_deadline;
        n_pattern  = r_pattern;
        if (stepped) begin
            if (phase_res.restart) begin
                n_step     = STEP_ONE;
                n_deadline = TIME_W'(1);
            end else begin
                n_step     = step_inc;
                n_deadline = r_in_time + TIME_W'(r_interval);
                n_pattern  = phase_res.pattern;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_deadline  <= '0;
            r_pattern   <= '0;
            r_interval  <= IVAL_RESET[IVAL_W-1:0];
        end else begin
            if (i_cfg_valid) begin
                r_interval <= i_cfg_data;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_step     <= n_step;
                    r_deadline <= n_deadline;
                    r_pattern  <= n_pattern;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_time <= i_s_axis_tdata;
        end
        if (advance && r_in_valid) begin
            r_out_pattern <= n_pattern;
            r_out_stepped <= stepped;
        end
    end

endmodule

FILE: design/lsps_checker.sv
// Port-level checker for the LED pattern sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "led_strip_pattern_sequencer_macros.svh"

module lsps_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [lsps_pkg::TIME_W-1:0]   i_s_axis_tdata,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [lsps_pkg::OUT_DW-1:0]   o_m_axis_tdata,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [lsps_pkg::IVAL_W-1:0]   i_cfg_data
);
    import lsps_pkg::*;

    // A held result keeps its payload until it is taken.
    `LSPS_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")

    // No result is pending right after reset.
    `LSPS_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

    // Input ready drops only when a result is waiting and stalled.
    `LSPS_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready, "input stalled without output stall")

    // A result that did not step repeats the pattern of the result just before it.
    `LSPS_ASSERT(a_no_step_hold, i_clk, i_rst_n, $past(o_m_axis_tvalid && i_m_axis_tready) && o_m_axis_tvalid && !o_m_axis_tdata[PAT_W] |-> o_m_axis_tdata[PAT_W-1:0] == $past(o_m_axis_tdata[PAT_W-1:0]), "pattern changed without a step")

endmodule

bind led_strip_pattern_sequencer lsps_checker u_lsps_checker (.*);

FILE: tb/sv/tb.sv
// Self-checking testbench for the LED pattern sequencer with its own step and pattern predictor.
`timescale 1ns / 1ps

module tb;

    import lsps_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;

    typedef struct {
        logic [PAT_W-1:0] pattern;
        logic             stepped;
    } t_led_frame;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [TIME_W-1:0]  i_s_axis_tdata = '0;   // [31:0] time_now
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]  o_m_axis_tdata;        // [7:0] led_pattern, [8] stepped
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [IVAL_W-1:0]  i_cfg_data = '0;       // [15:0] step_interval

    // Predicted block state.
    logic [IVAL_W-1:0]  pred_ival;
    logic [STEP_W-1:0]  pred_step;
    logic [TIME_W-1:0]  pred_deadline;
    logic [PAT_W-1:0]   pred_pattern;

    t_led_frame         frames_due[$];

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int n_errors      = 0;
    int n_samples     = 0;
    int n_results     = 0;
    int n_steps       = 0;
    int n_restarts    = 0;

    led_strip_pattern_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // The long output hold-off counts down here, apart from the random stalls.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        n_errors++;
        if (n_errors <= 20) begin
            $display("MISMATCH %s: expected %0h, got %0h at cycle %0d",
                     what, want, got, cycle_count);
        end
    endtask

    always @(posedge i_clk) begin : check_frames
        t_led_frame want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            if (frames_due.size() == 0) begin
                report_mismatch("result with no sample pending", 32'(0),
                                32'(o_m_axis_tdata));
            end else begin
                want = frames_due.pop_front();
                if (o_m_axis_tdata[PAT_W-1:0] !== want.pattern) begin
                    report_mismatch("led_pattern", 32'(want.pattern),
                                    32'(o_m_axis_tdata[PAT_W-1:0]));
                end
                if (o_m_axis_tdata[PAT_W] !== want.stepped) begin
                    report_mismatch("stepped", 32'(want.stepped), 32'(o_m_axis_tdata[PAT_W]));
                end
                if (o_m_axis_tdata[OUT_DW-1:PAT_W+1] !== '0) begin
                    report_mismatch("tdata padding", 32'(0),
                                    32'(o_m_axis_tdata[OUT_DW-1:PAT_W+1]));
                end
            end
        end
    end

    function automatic void drive_led(input int idx, input logic on);
        if (idx >= 0 && idx < PAT_W) begin
            pred_pattern[idx] = on;
        end
    endfunction

    // Applies the phase selected by the freshly incremented step.
    function automatic void advance_animation();
        int n;
        int s;
        int k;
        int j;
        int m;
        int idx;
        n = LED_COUNT;
        s = int'(pred_step);
        if (s >= 1 && s <= n) begin
            drive_led(s - 1, 1'b1);
        end else if (s > n && s < 2 * n) begin
            drive_led(s - n - 1, 1'b0);
        end else if (s >= 2 * n && s < 3 * n - 1) begin
            pred_pattern = '0;
            drive_led(n - 1, 1'b1);
            drive_led(3 * n - 2 - s, 1'b1);
        end else if (s >= 3 * n - 1 && s < 4 * n - 3) begin
            k = s - 3 * n + 2;
            if (k < n / 2) begin
                drive_led(n - 1 - k, 1'b1);
                drive_led(k, 1'b1);
            end else begin
                j = k - n / 2;
                drive_led((n - 1) / 2 - j, 1'b0);
                drive_led(n / 2 + j, 1'b0);
            end
        end else if (s >= 4 * n - 3 && s < 5 * n - 4) begin
            m = s - 4 * n + 5;
            idx = n - m;
            pred_pattern = '0;
            drive_led(idx, 1'b1);
            if (idx >= n / 2) begin
                drive_led(m, 1'b1);
            end
        end else begin
            pred_step = STEP_W'(1);
            pred_deadline = TIME_W'(1);
            n_restarts++;
        end
    endfunction

    function automatic void predict_frame(input logic [TIME_W-1:0] t);
        t_led_frame f;
        f.stepped = 1'b0;
        if (pred_deadline < t) begin
            f.stepped = 1'b1;
            pred_step = pred_step + 1'b1;
            pred_deadline = t + TIME_W'(pred_ival);
            n_steps++;
            advance_animation();
        end
        f.pattern = pred_pattern;
        frames_due.push_back(f);
    endfunction

    // Mostly samples just past the deadline so the animation keeps moving.
    function automatic logic [TIME_W-1:0] next_sample();
        int unsigned    pick;
        longint unsigned t;
        longint unsigned lim;
        longint unsigned span;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            t = $urandom_range(0, 32'hFFFE_FFFF);
        end else if (pick < 13) begin
            t = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFE);
        end else if (pick < 28) begin
            t = $urandom_range(0, pred_deadline);
        end else begin
            lim = 64'hFFFF_FFFF - pred_deadline;
            span = (pred_ival < lim - 1) ? pred_ival : lim - 1;
            t = pred_deadline + 1 + $urandom_range(0, span);
        end
        // A deadline of all ones could never be passed again, so steer around it.
        if (t > pred_deadline && t + pred_ival == 64'hFFFF_FFFF) begin
            t = (t > pred_deadline + 1) ? t - 1 : t + 1;
        end
        return t[TIME_W-1:0];
    endfunction

    // Entered and left just after a falling edge; tvalid stays up on return.
    task automatic send_sample(input logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= t;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_frame(t);
        n_samples++;
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_sample(next_sample());
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_interval(input logic [IVAL_W-1:0] ival);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ival;
        do @(posedge i_clk); while (!o_cfg_ready);
        pred_ival = ival;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_and_wrap();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        // Reset interval of 100: a sample equal to the deadline does not step.
        send_sample(32'd0);
        send_sample(32'd100);
        send_sample(32'd200);
        send_sample(32'd201);
        write_interval(16'd5);
        // The all-ones sample pushes the deadline past the top of the time range.
        send_sample(32'hFFFF_FFFF);
        send_sample(32'd4);
        send_sample(32'd5);
        send_sample(32'd10);
        send_sample(32'd11);
        write_interval(16'd0);
        for (int t = 12; t < 26; t++) begin
            send_sample(TIME_W'(t));
        end
    endtask

    task automatic test_random_phase(input logic [IVAL_W-1:0] ival, input int idle_pct,
                                     input int stall_pct, input int count);
        write_interval(ival);
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        send_random(count);
    endtask

    task automatic test_output_hold_off();
        write_interval(16'd1);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = 300;
        send_random(60);
    endtask

    task automatic test_sender_pause();
        write_interval(16'd37);
        src_idle_pct = 20;
        sink_stall_pct = 77;
        send_random(20);
        wait_idle();
        send_random(20);
    endtask

    initial begin
        pred_ival = IVAL_W'(IVAL_RESET);
        pred_step = '0;
        pred_deadline = '0;
        pred_pattern = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_and_wrap();
        test_random_phase(16'd0, 0, 0, 120);
        test_random_phase(16'hFFFF, 77, 0, 110);
        test_random_phase(IVAL_W'($urandom_range(1, 300)), 0, 77, 110);
        test_random_phase(IVAL_W'($urandom), 31, 31, 110);
        test_output_hold_off();
        test_sender_pause();

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        $display("Covered %0d samples and %0d results: %0d animation steps, %0d restarts.",
                 n_samples, n_results, n_steps, n_restarts);
        $display("Intervals from 0 to 65535, time wrap, idle and stall mixes, long hold-off.");
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
